// ===== rtl/lkvc_pkg.sv =====
// Shared constants and word types for the LRU key/value cache.
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_W = 5;
   localparam int DATA_W = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef struct packed {
      logic                     valid;
      logic                     action;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
   } lkvc_rsp_type;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key/value cache.
//
// Requests enter on start with req_action (get or put), req_key and req_value.
// A word is taken at each clock edge where start is high and busy is low; busy
// is high during reset and in the cycle right after it and low otherwise, so
// one request can be taken per cycle, back to back.
// Each request gives exactly one response: rsp_strobe is high for one cycle
// with rsp_found and rsp_read_value. A taken request is registered in req_ff,
// looked up and applied to the slots from that register, and its response is
// registered in the output flops before it is shown. Throughput is one request per
// cycle, set by the combinational tag match and rank update over all slots.
// The receiver cannot stall responses; they are never held.
// The capacity register is written through csr_valid/csr_wdata, always ready,
// and should only change while no request is in flight.
// Reset is synchronous: all slots become invalid, the live count returns to
// zero and the capacity returns to 16.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic                               rsp_found,
   output logic signed [lkvc_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]         csr_wdata
);

   lkvc_pkg::lkvc_req_type              req_ff, req_in;
   lkvc_pkg::lkvc_rsp_type              slot_rsp;
   logic [lkvc_pkg::CAP_W-1:0]          capacity_ff, capacity_in;
   logic                                busy_ff;
   logic                                rsp_strobe_ff;
   logic                                rsp_found_ff;
   logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value_ff;

   assign busy = busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      req_in.valid = start && !busy_ff;
      req_in.action = req_action;
      req_in.key = req_key;
      req_in.value = req_value;
      capacity_in = (csr_valid && csr_ready) ? csr_wdata : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         req_ff.valid <= 1'b0;
         capacity_ff <= lkvc_pkg::CAPACITY_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         req_ff.valid <= req_in.valid;
         req_ff.action <= req_in.action;
         req_ff.key <= req_in.key;
         req_ff.value <= req_in.value;
         capacity_ff <= capacity_in;
         rsp_strobe_ff <= req_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= slot_rsp.found;
      rsp_read_value_ff <= slot_rsp.read_value;
   end

   lkvc_slots #(
      .ENTRIES (ENTRIES)
   ) u_slots (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ff),
      .capacity (capacity_ff),
      .rsp      (slot_rsp)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

// ===== rtl/lkvc_slots.sv =====
// Slot array with parallel key match and recency rank update.
module lkvc_slots #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lkvc_pkg::lkvc_req_type         req,
   input  logic [lkvc_pkg::CAP_W-1:0]     capacity,
   output lkvc_pkg::lkvc_rsp_type         rsp
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   logic [ENTRIES-1:0]                          valid_ff, valid_in;
   logic [RANK_W-1:0]                           rank_ff [ENTRIES];
   logic [RANK_W-1:0]                           rank_in [ENTRIES];
   logic signed [lkvc_pkg::DATA_W-1:0]          key_ff [ENTRIES];
   logic signed [lkvc_pkg::DATA_W-1:0]          value_ff [ENTRIES];
   logic [CNT_W-1:0]                            live_ff, live_in;

   logic [ENTRIES-1:0]                          hit_vec;
   logic [ENTRIES-1:0]                          victim_vec;
   logic [ENTRIES-1:0]                          valid_post;
   logic [ENTRIES-1:0]                          free_vec;
   logic [ENTRIES-1:0]                          first_free;
   logic [ENTRIES-1:0]                          key_we;
   logic [ENTRIES-1:0]                          value_we;
   logic                                        hit;
   logic [RANK_W-1:0]                           hit_rank;
   logic [RANK_W-1:0]                           last_rank;
   logic signed [lkvc_pkg::DATA_W-1:0]          hit_value;
   logic [CMP_W-1:0]                            cap_ext;
   logic [CMP_W-1:0]                            eff_cap;
   logic                                        is_put;
   logic                                        do_touch;
   logic                                        do_insert;
   logic                                        evict;
   logic                                        slot_ok;

   always_comb begin
      hit_vec = '0;
      hit_rank = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (hit_vec[i]) begin
            hit_rank = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      hit = |hit_vec;

      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end

      is_put = (req.action == lkvc_pkg::ACT_PUT);
      do_touch = req.valid && hit;
      do_insert = req.valid && is_put && !hit;
      evict = do_insert && (CMP_W'(live_ff) >= eff_cap);

      // The oldest valid entry always holds the rank live_count - 1.
      last_rank = RANK_W'(live_ff - CNT_W'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == last_rank);
      end

      valid_post = evict ? (valid_ff & ~victim_vec) : valid_ff;
      free_vec = ~valid_post;
      first_free = free_vec & (~free_vec + ENTRIES'(1));
      slot_ok = |free_vec;

      valid_in = valid_ff;
      key_we = '0;
      value_we = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_touch) begin
            if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            if (hit_vec[i]) begin
               rank_in[i] = '0;
               value_we[i] = is_put;
            end
         end
         if (do_insert) begin
            if (evict && victim_vec[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i] = '0;
            end
            if (slot_ok && valid_post[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            if (first_free[i]) begin
               valid_in[i] = 1'b1;
               rank_in[i] = '0;
               key_we[i] = 1'b1;
               value_we[i] = 1'b1;
            end
         end
      end

      live_in = live_ff;
      if (do_insert) begin
         live_in = live_ff - CNT_W'(evict) + CNT_W'(slot_ok);
      end

      rsp.found = hit;
      rsp.read_value = (hit && !is_put) ? hit_value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         live_ff <= live_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= req.key;
         end
         if (value_we[i]) begin
            value_ff[i] <= req.value;
         end
      end
   end

   a_live_bounded: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(ENTRIES))
      else $error("live count exceeds the number of slots");

   a_live_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(live_ff))
      else $error("live count differs from the number of valid slots");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      req.valid |-> $onehot0(hit_vec))
      else $error("key matches more than one slot");

   a_insert_lands: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (live_ff != '0))
      else $error("insert left the cache empty");

endmodule

// ===== sim/lkvc_checker.sv =====
// Response checker for the LRU key/value cache: predicts each response and compares it.
module lkvc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_action,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_value,
   input  logic                               rsp_strobe,
   input  logic                               rsp_found,
   input  logic signed [lkvc_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]         csr_wdata,
   output int                                 failures,
   output int                                 pending,
   output int                                 checked,
   output int                                 hits,
   output int                                 evictions
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = lkvc_pkg::ENTRIES_DEFAULT;

   logic                               slot_live [SLOTS];
   logic signed [lkvc_pkg::DATA_W-1:0] slot_tag [SLOTS];
   logic signed [lkvc_pkg::DATA_W-1:0] slot_data [SLOTS];
   int unsigned                        slot_age [SLOTS];
   int unsigned                        occupancy;
   logic [lkvc_pkg::CAP_W-1:0]         cap_reg;
   lkvc_pkg::lkvc_rsp_type             predicted_rsp_q [$];
   lkvc_pkg::lkvc_rsp_type             oldest_rsp;

   function automatic int unsigned cap_limit();
      int unsigned c;
      c = cap_reg;
      if (c == 0) begin
         c = 1;
      end
      if (c > SLOTS) begin
         c = SLOTS;
      end
      return c;
   endfunction

   function automatic void make_newest(int s);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && slot_age[i] < slot_age[s]) begin
            slot_age[i]++;
         end
      end
      slot_age[s] = 0;
   endfunction

   function automatic lkvc_pkg::lkvc_rsp_type predict_access(
      logic                               act,
      logic signed [lkvc_pkg::DATA_W-1:0] k,
      logic signed [lkvc_pkg::DATA_W-1:0] v);
      int                     hit_slot;
      int                     victim;
      int                     free_slot;
      lkvc_pkg::lkvc_rsp_type r;
      hit_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit_slot < 0 && slot_live[i] && slot_tag[i] == k) begin
            hit_slot = i;
         end
      end
      r.found = (hit_slot >= 0);
      r.read_value = '0;
      if (hit_slot >= 0) begin
         if (act == lkvc_pkg::ACT_GET) begin
            r.read_value = slot_data[hit_slot];
            hits++;
         end else begin
            slot_data[hit_slot] = v;
         end
         make_newest(hit_slot);
      end else if (act == lkvc_pkg::ACT_PUT) begin
         if (occupancy >= cap_limit()) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && (victim < 0 || slot_age[i] >= slot_age[victim])) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               slot_live[victim] = 1'b0;
               slot_age[victim] = 0;
               occupancy--;
               evictions++;
            end
         end
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (free_slot < 0 && !slot_live[i]) begin
               free_slot = i;
            end
         end
         if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i]) begin
                  slot_age[i]++;
               end
            end
            slot_live[free_slot] = 1'b1;
            slot_tag[free_slot] = k;
            slot_data[free_slot] = v;
            slot_age[free_slot] = 0;
            occupancy++;
         end
      end
      return r;
   endfunction

   task automatic report_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_tag[i] = '0;
            slot_data[i] = '0;
            slot_age[i] = 0;
         end
         occupancy = 0;
         cap_reg = lkvc_pkg::CAPACITY_RESET;
         predicted_rsp_q.delete();
         failures = 0;
         checked = 0;
         hits = 0;
         evictions = 0;
      end else begin
         if (rsp_strobe) begin
            if (predicted_rsp_q.size() == 0) begin
               report_failure($sformatf("unexpected response word: found=%0b read_value=%0d",
                                        rsp_found, rsp_read_value));
            end else begin
               oldest_rsp = predicted_rsp_q[0];
               predicted_rsp_q.delete(0);
               checked++;
               if (rsp_found !== oldest_rsp.found ||
                   rsp_read_value !== oldest_rsp.read_value) begin
                  report_failure($sformatf(
                     {"response mismatch: expected found=%0b read_value=%0d, ",
                      "got found=%0b read_value=%0d"},
                     oldest_rsp.found, oldest_rsp.read_value, rsp_found, rsp_read_value));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            cap_reg = csr_wdata;
         end
         if (start && !busy) begin
            predicted_rsp_q.push_back(predict_access(req_action, req_key, req_value));
         end
      end
      pending = predicted_rsp_q.size();
   end

endmodule

// ===== sim/lru_key_value_cache_tb.sv =====
// Testbench top for the LRU key/value cache: clock, reset, stimulus and verdict.
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 50000;
   localparam int POOL_SIZE = 24;
   localparam logic signed [lkvc_pkg::DATA_W-1:0] KEY_MIN = 32'sh80000000;
   localparam logic signed [lkvc_pkg::DATA_W-1:0] KEY_MAX = 32'sh7FFFFFFF;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_action;
   logic signed [lkvc_pkg::DATA_W-1:0] req_key;
   logic signed [lkvc_pkg::DATA_W-1:0] req_value;
   logic                               rsp_strobe;
   logic                               rsp_found;
   logic signed [lkvc_pkg::DATA_W-1:0] rsp_read_value;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [lkvc_pkg::CAP_W-1:0]         csr_wdata;

   int                                 failures;
   int                                 pending;
   int                                 checked;
   int                                 hits;
   int                                 evictions;
   int                                 cycle_count = 0;
   int                                 requests_sent;
   int                                 sender_idle_pct;
   logic signed [lkvc_pkg::DATA_W-1:0] key_pool [POOL_SIZE];

   lru_key_value_cache dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   lkvc_checker u_lkvc_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending        (pending),
      .checked        (checked),
      .hits           (hits),
      .evictions      (evictions)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic issue_request(input logic act,
                                input logic signed [lkvc_pkg::DATA_W-1:0] k,
                                input logic signed [lkvc_pkg::DATA_W-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_key <= k;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
      quiesce();
      csr_valid <= 1'b1;
      csr_wdata <= c;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n, input int idle_pct, input int pool_span);
      logic                               act;
      logic signed [lkvc_pkg::DATA_W-1:0] k;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < n; i++) begin
         act = ($urandom_range(99) < 55) ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET;
         if ($urandom_range(9) == 0) begin
            k = $urandom;
         end else begin
            k = key_pool[$urandom_range(pool_span - 1)];
         end
         issue_request(act, k, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = lkvc_pkg::ACT_GET;
      req_key = '0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      requests_sent = 0;
      sender_idle_pct = 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_capacity(5'd2);
      issue_request(lkvc_pkg::ACT_GET, 32'sd0, KEY_MAX);
      issue_request(lkvc_pkg::ACT_PUT, KEY_MIN, KEY_MAX);
      issue_request(lkvc_pkg::ACT_PUT, KEY_MAX, KEY_MIN);
      issue_request(lkvc_pkg::ACT_GET, KEY_MIN, 32'sd0);
      issue_request(lkvc_pkg::ACT_PUT, 32'sd0, -32'sd1);
      issue_request(lkvc_pkg::ACT_GET, KEY_MAX, 32'sd0);
      issue_request(lkvc_pkg::ACT_PUT, KEY_MIN, -32'sd1);
      issue_request(lkvc_pkg::ACT_GET, KEY_MIN, -32'sd1);
      issue_request(lkvc_pkg::ACT_GET, 32'sd0, 32'sd0);

      write_capacity(5'd0);
      issue_request(lkvc_pkg::ACT_PUT, 32'sd1, 32'sd5);
      issue_request(lkvc_pkg::ACT_GET, 32'sd0, 32'sd0);
      issue_request(lkvc_pkg::ACT_GET, KEY_MIN, 32'sd0);
      issue_request(lkvc_pkg::ACT_PUT, 32'sd2, 32'sd6);
      issue_request(lkvc_pkg::ACT_GET, 32'sd1, 32'sd0);

      write_capacity(5'd31);
      issue_request(lkvc_pkg::ACT_PUT, KEY_MAX, 32'sd1);
      issue_request(lkvc_pkg::ACT_PUT, -32'sd1, KEY_MIN);
      issue_request(lkvc_pkg::ACT_GET, 32'sd2, 32'sd0);
      issue_request(lkvc_pkg::ACT_GET, KEY_MAX, KEY_MAX);
      issue_request(lkvc_pkg::ACT_GET, -32'sd1, 32'sd0);

      write_capacity(5'd16);
      random_phase(140, 26, 24);
      write_capacity(5'd4);
      random_phase(110, 84, 8);
      write_capacity(5'd1);
      random_phase(50, 0, 3);
      write_capacity(5'd12);
      random_phase(90, 0, 20);
      quiesce();

      $display("Covered %0d requests: a directed part, then four random phases at capacity",
               requests_sent);
      $display("16, 4, 1 and 12 with %0d responses checked, %0d get hits, %0d evictions.",
               checked, hits, evictions);
      if (failures == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_slots.sv
rtl/lru_key_value_cache.sv
sim/lkvc_checker.sv
sim/lru_key_value_cache_tb.sv
